[src/wbss_pkg.sv]
// shared types and constants for the wildcard byte signature scan
package wbss_pkg;

   localparam int CsrDataWidth  = 64;
   localparam int CsrIndexWidth = 3;
   localparam int LengthWidth   = 5;
   localparam int OffsetWidth   = 32;
   localparam int AddressWidth  = 64;
   localparam int ByteWidth     = 8;
   localparam int BytesPerWord  = 8;

   localparam logic [ByteWidth-1:0] WildcardByte = 8'hFF;

   typedef enum logic [CsrIndexWidth-1:0] {
      REG_PATTERN_LOW  = 3'd0,
      REG_PATTERN_HIGH = 3'd1,
      REG_PATTERN_LEN  = 3'd2,
      REG_BASE_ADDRESS = 3'd3,
      REG_RESULT_OFFS  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

[src/wildcard_byte_signature_scan_core.sv]
// top level of the wildcard byte signature scan
//
// Takes one byte per beat on the req_ channel, with req_last_of_range marking
// the final byte of a range, and compares the newest pattern_length bytes
// against the pattern held in the csr_ registers (0xFF in the pattern matches
// any byte). The first match in a range gives one rsp_ beat with found set and
// the address base + window start + signed offset; later bytes of that range
// are dropped. A range that ends without a match gives one beat with found
// clear and address 0 on its last byte. The next byte starts a new range.
// A byte enters every cycle while req_ready is high; the window is a row of
// byte cells shifting in lockstep and compared in parallel. The compare
// result is registered at the edge that takes the byte, then the address add
// in the result register once it can load; rsp_valid rises with that load.
// When the receiver stalls, the result register and the compare stage each
// hold one beat; req_ready drops only when both are full.
// Reset is synchronous; it empties both stages, clears the window and sets
// the registers to their reset values (pattern length 1).
module wildcard_byte_signature_scan_core #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write,
   input  logic [wbss_pkg::CsrIndexWidth-1:0]       csr_index,
   input  logic [wbss_pkg::CsrDataWidth-1:0]        csr_data,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [wbss_pkg::ByteWidth-1:0]           req_data_byte,
   input  logic                                     req_last_of_range,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_found,
   output logic [wbss_pkg::AddressWidth-1:0]        rsp_match_address
);

   localparam int LW = $clog2(MAX_PATTERN + 1);
   localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int AW = wbss_pkg::AddressWidth;
   localparam int BW = wbss_pkg::ByteWidth;

   logic [wbss_pkg::CsrDataWidth-1:0]        pattern_low_ff;
   logic [wbss_pkg::CsrDataWidth-1:0]        pattern_high_ff;
   logic [wbss_pkg::LengthWidth-1:0]         length_ff;
   logic [AW-1:0]                            base_ff;
   logic signed [wbss_pkg::OffsetWidth-1:0]  offset_ff;

   logic [LW-1:0]          eff_len;
   logic [BW-1:0]          pattern [MAX_PATTERN];
   logic [BW-1:0]          chain [MAX_PATTERN+1];
   logic [MAX_PATTERN-1:0] cell_hit;
   wbss_pkg::cell_ctrl_type cell_ctrl;

   logic          accept;
   logic          hit;
   logic          a_load;
   logic          advance;
   logic [AW-1:0] seen_ff;
   logic [AW-1:0] seen_in;
   logic [AW-1:0] seen_new;
   logic          done_ff;
   logic          done_in;
   logic          a_valid_ff;
   logic          a_valid_in;
   logic          a_found_ff;
   logic [AW-1:0] a_start_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         length_ff       <= wbss_pkg::LengthWidth'(1);
         base_ff         <= '0;
         offset_ff       <= '0;
      end else if (csr_write) begin
         case (csr_index)
            wbss_pkg::REG_PATTERN_LOW:  pattern_low_ff  <= csr_data;
            wbss_pkg::REG_PATTERN_HIGH: pattern_high_ff <= csr_data;
            wbss_pkg::REG_PATTERN_LEN:  length_ff <= csr_data[wbss_pkg::LengthWidth-1:0];
            wbss_pkg::REG_BASE_ADDRESS: base_ff   <= csr_data;
            wbss_pkg::REG_RESULT_OFFS:  offset_ff <= csr_data[wbss_pkg::OffsetWidth-1:0];
            default: ;
         endcase
      end
   end

   // zero means one, clamp to the window depth
   always_comb begin
      if (length_ff == '0) begin
         eff_len = LW'(1);
      end else if (int'(length_ff) > MAX_PATTERN) begin
         eff_len = LW'(MAX_PATTERN);
      end else begin
         eff_len = LW'(length_ff);
      end
   end

   // pattern bytes, wildcards past the two words
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pattern
      if (k < wbss_pkg::BytesPerWord) begin : g_low
         assign pattern[k] = pattern_low_ff[k*BW +: BW];
      end else if (k < 2 * wbss_pkg::BytesPerWord) begin : g_high
         assign pattern[k] = pattern_high_ff[(k-wbss_pkg::BytesPerWord)*BW +: BW];
      end else begin : g_wild
         assign pattern[k] = wbss_pkg::WildcardByte;
      end
   end

   assign accept   = req_valid && req_ready;
   assign seen_new = seen_ff + AW'(1);

   assign cell_ctrl.shift = accept && !done_ff;
   assign cell_ctrl.clear = reset || (accept && req_last_of_range);

   assign chain[0] = req_data_byte;

   // cell j takes in the byte j steps old and meets pattern byte len-1-j
   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      logic [LW-1:0] pat_sel;
      logic          in_use;
      assign pat_sel = eff_len - LW'(1) - LW'(j);
      assign in_use  = LW'(j) < eff_len;
      wbss_cell u_cell (
         .clock        (clock),
         .ctrl         (cell_ctrl),
         .byte_in      (chain[j]),
         .pattern_byte (pattern[pat_sel[IW-1:0]]),
         .in_use       (in_use),
         .byte_out     (chain[j+1]),
         .hit          (cell_hit[j])
      );
   end

   assign hit    = !done_ff && (seen_new >= AW'(eff_len)) && (&cell_hit);
   assign a_load = accept && (hit || (req_last_of_range && !done_ff));

   always_comb begin
      seen_in = seen_ff;
      done_in = done_ff;
      if (accept && req_last_of_range) begin
         seen_in = '0;
         done_in = 1'b0;
      end else if (accept && !done_ff) begin
         seen_in = seen_new;
         done_in = hit;
      end
      a_valid_in = a_valid_ff;
      if (a_load) begin
         a_valid_in = 1'b1;
      end else if (advance) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= '0;
         done_ff    <= 1'b0;
         a_valid_ff <= 1'b0;
      end else begin
         seen_ff    <= seen_in;
         done_ff    <= done_in;
         a_valid_ff <= a_valid_in;
      end
      if (a_load) begin
         a_found_ff <= hit;
         a_start_ff <= seen_new - AW'(eff_len);
      end
   end

   assign req_ready = !a_valid_ff || advance;

   wbss_result_stage u_result (
      .clock             (clock),
      .reset             (reset),
      .load              (a_valid_ff && advance),
      .found             (a_found_ff),
      .start             (a_start_ff),
      .base_address      (base_ff),
      .result_offset     (offset_ff),
      .can_load          (advance),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_match_address (rsp_match_address)
   );

endmodule

[src/wbss_cell.sv]
// one window byte cell: holds a byte, passes it on, compares the incoming byte
module wbss_cell (
   input  logic                             clock,
   input  wbss_pkg::cell_ctrl_type          ctrl,
   input  logic [wbss_pkg::ByteWidth-1:0]   byte_in,
   input  logic [wbss_pkg::ByteWidth-1:0]   pattern_byte,
   input  logic                             in_use,
   output logic [wbss_pkg::ByteWidth-1:0]   byte_out,
   output logic                             hit
);

   logic [wbss_pkg::ByteWidth-1:0] byte_ff;
   logic [wbss_pkg::ByteWidth-1:0] byte_in_next;

   // compare against the value this cell takes on the shift
   assign hit = !in_use || (pattern_byte == wbss_pkg::WildcardByte) ||
                (pattern_byte == byte_in);

   always_comb begin
      byte_in_next = byte_ff;
      if (ctrl.clear) begin
         byte_in_next = '0;
      end else if (ctrl.shift) begin
         byte_in_next = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_next;
   end

   assign byte_out = byte_ff;

endmodule

[src/wbss_result_stage.sv]
// result register: forms the match address and holds the beat for the receiver
module wbss_result_stage (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load,
   input  logic                                   found,
   input  logic [wbss_pkg::AddressWidth-1:0]      start,
   input  logic [wbss_pkg::AddressWidth-1:0]      base_address,
   input  logic signed [wbss_pkg::OffsetWidth-1:0] result_offset,
   output logic                                   can_load,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_found,
   output logic [wbss_pkg::AddressWidth-1:0]      rsp_match_address
);

   logic                                valid_ff;
   logic                                valid_in;
   logic                                found_ff;
   logic [wbss_pkg::AddressWidth-1:0]   address_ff;
   logic [wbss_pkg::AddressWidth-1:0]   address_in;
   logic [wbss_pkg::AddressWidth-1:0]   offset_ext;

   assign offset_ext = wbss_pkg::AddressWidth'(result_offset);
   assign can_load   = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
      address_in = found ? (base_address + start + offset_ext) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         found_ff   <= found;
         address_ff <= address_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_match_address = address_ff;

endmodule

[src/wbss_checker.sv]
// port-level assertions for the scan core, bound to the top level
module wbss_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_found,
   input logic [wbss_pkg::AddressWidth-1:0]   rsp_match_address
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_match_address))
      else $error("stalled rsp beat changed");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_address == '0)
      else $error("miss beat with nonzero address");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req not ready right after reset");

endmodule

bind wildcard_byte_signature_scan_core wbss_checker u_wbss_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_found         (rsp_found),
   .rsp_match_address (rsp_match_address)
);

[tb/tb.sv]
// self-checking testbench for the wildcard byte signature scan core
`timescale 1ns / 1ps

module tb;

   localparam int PatternMax  = 16;
   localparam int DrainCycles = 6;
   localparam int IdlePercent = 36;
   localparam int RandomBeats = 650;

   typedef struct packed {
      logic                              found;
      logic [wbss_pkg::AddressWidth-1:0] address;
   } scan_result_type;

   typedef enum logic [1:0] {
      ROW_BEAT,
      ROW_BEAT_TYPED,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type                      kind;
      wbss_pkg::csr_index_type           index;
      logic [wbss_pkg::CsrDataWidth-1:0] data;
      logic [wbss_pkg::ByteWidth-1:0]    octet;
      logic                              last;
      logic                              t_found;
      logic [wbss_pkg::AddressWidth-1:0] t_address;
   } script_row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_write = 1'b0;
   logic [wbss_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [wbss_pkg::CsrDataWidth-1:0]  csr_data = '0;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [wbss_pkg::ByteWidth-1:0]     req_data_byte = '0;
   logic                               req_last_of_range = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic                               rsp_found;
   logic [wbss_pkg::AddressWidth-1:0]  rsp_match_address;

   // predictor copy of the registers and the scan state
   logic [2*wbss_pkg::CsrDataWidth-1:0] pattern_word;
   logic [wbss_pkg::LengthWidth-1:0]    pattern_len_reg;
   logic [wbss_pkg::AddressWidth-1:0]   base_reg;
   logic [wbss_pkg::OffsetWidth-1:0]    offset_reg;
   logic [wbss_pkg::ByteWidth-1:0]      scan_window [PatternMax];
   logic [63:0]                         range_count;
   bit                                  range_hit;

   script_row_type  script [$];
   scan_result_type expected_hits [$];
   scan_result_type checked_hit;
   bit              calm = 1'b0;
   int              error_count = 0;
   int              beats_scanned = 0;
   int              ranges_closed = 0;
   int              hits_found = 0;
   int              misses_reported = 0;

   wildcard_byte_signature_scan_core #(
      .MAX_PATTERN(PatternMax)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_of_range (req_last_of_range),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_match_address (rsp_match_address)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic void script_add(input row_kind_type kind,
                                      input wbss_pkg::csr_index_type index,
                                      input logic [wbss_pkg::CsrDataWidth-1:0] data,
                                      input logic [wbss_pkg::ByteWidth-1:0] octet,
                                      input logic last, input logic t_found,
                                      input logic [wbss_pkg::AddressWidth-1:0] t_address);
      script.insert(script.size(), '{kind, index, data, octet, last, t_found, t_address});
   endfunction

   function automatic int active_length();
      int n;
      n = int'(pattern_len_reg);
      if (n == 0) n = 1;
      if (n > PatternMax) n = PatternMax;
      return n;
   endfunction

   function automatic logic [wbss_pkg::CsrDataWidth-1:0] pattern_mix();
      logic [wbss_pkg::CsrDataWidth-1:0] word;
      int                                style;
      style = $urandom_range(0, 9);
      for (int k = 0; k < wbss_pkg::BytesPerWord; k++) begin
         word[8*k +: 8] = ($urandom_range(0, 3) == 0) ? wbss_pkg::WildcardByte :
                          8'($urandom);
      end
      if (style == 0) word = '0;
      else if (style == 1) word = '1;
      return word;
   endfunction

   task automatic scan_restart();
      for (int k = 0; k < PatternMax; k++) scan_window[k] = '0;
      range_count = '0;
      range_hit = 1'b0;
   endtask

   task automatic scan_predict(input logic [wbss_pkg::ByteWidth-1:0] octet, input logic last,
                               output bit produced, output scan_result_type res);
      int n;
      bit agree;
      produced = 1'b0;
      res = '0;
      if (!range_hit) begin
         n = active_length();
         for (int k = PatternMax - 1; k > 0; k--) scan_window[k] = scan_window[k-1];
         scan_window[0] = octet;
         range_count = range_count + 64'd1;
         if (range_count >= 64'(n)) begin
            agree = 1'b1;
            for (int k = 0; k < n; k++) begin
               if (pattern_word[8*k +: 8] != wbss_pkg::WildcardByte &&
                   pattern_word[8*k +: 8] != scan_window[n-1-k]) agree = 1'b0;
            end
            if (agree) begin
               produced = 1'b1;
               res.found = 1'b1;
               res.address = base_reg + (range_count - 64'(n)) +
                  {{(wbss_pkg::AddressWidth-wbss_pkg::OffsetWidth)
                    {offset_reg[wbss_pkg::OffsetWidth-1]}}, offset_reg};
               range_hit = 1'b1;
            end
         end
      end
      if (last) begin
         if (!produced && !range_hit) begin
            produced = 1'b1;
            res = '0;
         end
         scan_restart();
      end
   endtask

   task automatic csr_put(input logic [wbss_pkg::CsrIndexWidth-1:0] index,
                          input logic [wbss_pkg::CsrDataWidth-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      case (index)
         wbss_pkg::REG_PATTERN_LOW:
            pattern_word[wbss_pkg::CsrDataWidth-1:0] = data;
         wbss_pkg::REG_PATTERN_HIGH:
            pattern_word[2*wbss_pkg::CsrDataWidth-1:wbss_pkg::CsrDataWidth] = data;
         wbss_pkg::REG_PATTERN_LEN:  pattern_len_reg = data[wbss_pkg::LengthWidth-1:0];
         wbss_pkg::REG_BASE_ADDRESS: base_reg = data;
         wbss_pkg::REG_RESULT_OFFS:  offset_reg = data[wbss_pkg::OffsetWidth-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic scan_send(input logic [wbss_pkg::ByteWidth-1:0] octet, input logic last,
                            input bit use_typed, input scan_result_type typed);
      bit              produced;
      scan_result_type res;
      csr_write <= 1'b0;
      while (!calm && $urandom_range(0, 99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= octet;
      req_last_of_range <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      scan_predict(octet, last, produced, res);
      beats_scanned++;
      if (last) ranges_closed++;
      if (use_typed) begin
         res = typed;
         produced = 1'b1;
      end
      if (produced) begin
         expected_hits.insert(expected_hits.size(), res);
         if (res.found) hits_found++;
         else misses_reported++;
      end
   endtask

   // result side: random stalls, compare each beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual found %0b address %h",
                     $time, rsp_found, rsp_match_address);
            error_count++;
         end else begin
            checked_hit = expected_hits.pop_front();
            if (rsp_found !== checked_hit.found) begin
               $display("%0t: found mismatch, expected %0b actual %0b",
                        $time, checked_hit.found, rsp_found);
               error_count++;
            end
            if (rsp_match_address !== checked_hit.address) begin
               $display("%0t: match_address mismatch, expected %h actual %h",
                        $time, checked_hit.address, rsp_match_address);
               error_count++;
            end
         end
      end
      rsp_ready <= calm || $urandom_range(0, 99) >= IdlePercent;
   end

   initial begin
      logic [wbss_pkg::ByteWidth-1:0]    range_bytes [$];
      logic [wbss_pkg::CsrDataWidth-1:0] wide;
      bit                                was_beat;
      int                                n, span, spot, flip, len_pick, phase, guard;
      int                                directed_beats;

      pattern_word    = '0;
      pattern_len_reg = wbss_pkg::LengthWidth'(1);
      base_reg        = '0;
      offset_reg      = '0;
      scan_restart();

      // after reset: pattern byte 0 is zero with length 1
      script_add(ROW_BEAT_TYPED, wbss_pkg::REG_PATTERN_LOW, '0, 8'h00, 1'b0, 1'b1, 64'h0);
      script_add(ROW_BEAT, wbss_pkg::REG_PATTERN_LOW, '0, 8'h37, 1'b1, 1'b0, 64'h0);
      script_add(ROW_BEAT_TYPED, wbss_pkg::REG_PATTERN_LOW, '0, 8'h5A, 1'b1, 1'b0, 64'h0);
      // zero length acts as one, offset of minus one, match on the last beat
      script_add(ROW_CSR, wbss_pkg::REG_PATTERN_LEN, 64'h0, '0, 1'b0, 1'b0, 64'h0);
      script_add(ROW_CSR, wbss_pkg::REG_PATTERN_LOW, 64'hAB, '0, 1'b0, 1'b0, 64'h0);
      script_add(ROW_CSR, wbss_pkg::REG_BASE_ADDRESS, 64'h1000, '0, 1'b0, 1'b0, 64'h0);
      script_add(ROW_CSR, wbss_pkg::REG_RESULT_OFFS, '1, '0, 1'b0, 1'b0, 64'h0);
      script_add(ROW_BEAT, wbss_pkg::REG_PATTERN_LOW, '0, 8'h12, 1'b0, 1'b0, 64'h0);
      script_add(ROW_BEAT_TYPED, wbss_pkg::REG_PATTERN_LOW, '0, 8'hAB, 1'b1, 1'b1, 64'h1000);
      // length saturates at sixteen, all wildcards, address wraps
      script_add(ROW_CSR, wbss_pkg::REG_PATTERN_LEN, '1, '0, 1'b0, 1'b0, 64'h0);
      script_add(ROW_CSR, wbss_pkg::REG_PATTERN_LOW, '1, '0, 1'b0, 1'b0, 64'h0);
      script_add(ROW_CSR, wbss_pkg::REG_PATTERN_HIGH, '1, '0, 1'b0, 1'b0, 64'h0);
      script_add(ROW_CSR, wbss_pkg::REG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFF0, '0,
                 1'b0, 1'b0, 64'h0);
      script_add(ROW_CSR, wbss_pkg::REG_RESULT_OFFS, 64'h8000_0000_7FFF_FFFF, '0,
                 1'b0, 1'b0, 64'h0);
      // range shorter than the pattern
      script_add(ROW_BEAT, wbss_pkg::REG_PATTERN_LOW, '0, 8'h00, 1'b0, 1'b0, 64'h0);
      script_add(ROW_BEAT, wbss_pkg::REG_PATTERN_LOW, '0, 8'hFF, 1'b0, 1'b0, 64'h0);
      script_add(ROW_BEAT_TYPED, wbss_pkg::REG_PATTERN_LOW, '0, 8'h80, 1'b1, 1'b0, 64'h0);
      for (int k = 0; k < 8; k++) begin
         script_add(ROW_BEAT, wbss_pkg::REG_PATTERN_LOW, '0, 8'(1 << k), 1'b0, 1'b0, 64'h0);
      end
      for (int k = 0; k < 8; k++) begin
         script_add(ROW_BEAT, wbss_pkg::REG_PATTERN_LOW, '0, ~8'(1 << k), 1'b0, 1'b0, 64'h0);
      end
      // beat after the match is dropped
      script_add(ROW_BEAT, wbss_pkg::REG_PATTERN_LOW, '0, 8'h55, 1'b1, 1'b0, 64'h0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      was_beat = 1'b0;
      foreach (script[r]) begin
         if (script[r].kind == ROW_CSR) begin
            if (was_beat) settle_block();
            csr_put(script[r].index, script[r].data);
            was_beat = 1'b0;
         end else begin
            scan_send(script[r].octet, script[r].last, script[r].kind == ROW_BEAT_TYPED,
                      '{script[r].t_found, script[r].t_address});
            was_beat = 1'b1;
         end
      end

      directed_beats = beats_scanned;
      phase = 0;
      while ((beats_scanned - directed_beats) < RandomBeats) begin
         settle_block();
         calm = (phase == 3 || phase == 4);

         csr_put(wbss_pkg::REG_PATTERN_LOW, pattern_mix());
         csr_put(wbss_pkg::REG_PATTERN_HIGH, pattern_mix());
         case ($urandom_range(0, 7))
            0: len_pick = 0;
            1: len_pick = 1;
            2: len_pick = PatternMax;
            3: len_pick = $urandom_range(PatternMax + 1, 31);
            default: len_pick = $urandom_range(2, PatternMax - 1);
         endcase
         wide = {$urandom, $urandom};
         wide[wbss_pkg::LengthWidth-1:0] = wbss_pkg::LengthWidth'(len_pick);
         csr_put(wbss_pkg::REG_PATTERN_LEN, wide);
         case ($urandom_range(0, 4))
            0: wide = '0;
            1: wide = '1;
            2: wide = '1 - 64'($urandom_range(0, 64));
            default: wide = {$urandom, $urandom};
         endcase
         csr_put(wbss_pkg::REG_BASE_ADDRESS, wide);
         wide = {$urandom, $urandom};
         case ($urandom_range(0, 5))
            0: wide[wbss_pkg::OffsetWidth-1:0] = 32'h8000_0000;
            1: wide[wbss_pkg::OffsetWidth-1:0] = 32'h7FFF_FFFF;
            2: wide[wbss_pkg::OffsetWidth-1:0] = '0;
            3: wide[wbss_pkg::OffsetWidth-1:0] = '1;
            default: ;
         endcase
         csr_put(wbss_pkg::REG_RESULT_OFFS, wide);
         // unused register slots
         if ($urandom_range(0, 3) == 0) begin
            csr_put(wbss_pkg::REG_RESULT_OFFS +
                    wbss_pkg::CsrIndexWidth'($urandom_range(1, 3)),
                    {$urandom, $urandom});
         end

         repeat ($urandom_range(3, 8)) begin
            n = active_length();
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 20);
            range_bytes.delete();
            repeat (span) range_bytes.insert(range_bytes.size(), 8'($urandom));
            if (span >= n && $urandom_range(0, 9) < 7) begin
               spot = $urandom_range(0, span - n);
               for (int k = 0; k < n; k++) begin
                  if (pattern_word[8*k +: 8] != wbss_pkg::WildcardByte) begin
                     range_bytes[spot + k] = pattern_word[8*k +: 8];
                  end
               end
               // broken copy of the pattern
               if ($urandom_range(0, 5) == 0) begin
                  flip = spot + $urandom_range(0, n - 1);
                  range_bytes[flip] = range_bytes[flip] ^ 8'(1 << $urandom_range(0, 7));
               end
            end
            foreach (range_bytes[k]) begin
               scan_send(range_bytes[k], k == span - 1, 1'b0, '0);
            end
         end
         phase++;
      end

      req_valid <= 1'b0;
      guard = 0;
      while (expected_hits.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DrainCycles) @(posedge clock);
      if (expected_hits.size() != 0) begin
         $display("%0t: %0d results never came, first expected found %0b address %h",
                  $time, expected_hits.size(), expected_hits[0].found,
                  expected_hits[0].address);
         error_count += expected_hits.size();
      end

      $display("sent %0d bytes in %0d ranges across %0d pattern settings",
               beats_scanned, ranges_closed, phase + 3);
      $display("checked %0d matches and %0d ranges without a match, %0d errors",
               hits_found, misses_reported, error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
src/wbss_pkg.sv
src/wbss_cell.sv
src/wbss_result_stage.sv
src/wildcard_byte_signature_scan_core.sv
src/wbss_checker.sv
tb/tb.sv
